### sv/ring_queue_pointer_control_assert.svh
// Assertion macros shared by the ring queue pointer control modules.
`ifndef RING_QUEUE_POINTER_CONTROL_ASSERT_SVH
`define RING_QUEUE_POINTER_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RQPC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ring queue pointer control: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RQPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ring queue pointer control: next-cycle check failed");

`endif

### sv/rqpc_pkg.sv
// Types and constants of the ring queue pointer control.
package rqpc_pkg;

   localparam int RING_MAX       = 1024;
   localparam int ITEM_BITS      = 11;
   localparam int SLOT_BITS      = 10;
   localparam int COUNT_BITS     = 32;
   localparam int CSR_INDEX_BITS = 8;

   // Command codes of an input item; the unused code acts as a status query.
   localparam logic [1:0] CMD_QUERY = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_RING_ITEMS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SYNC_MODE  = CSR_INDEX_BITS'(1);

   typedef enum logic [1:0] {
      ST_GRANTED   = 2'd0,
      ST_SHORT     = 2'd1,
      ST_LAPPED    = 2'd2,
      ST_BAD_COUNT = 2'd3
   } status_type;

   // Active configuration as seen by the pointer logic.
   typedef struct packed {
      logic [ITEM_BITS-1:0] ring_items;
      logic                 sync_mode;
      logic                 clear;
   } cfg_type;

   // One result item.
   typedef struct packed {
      status_type           status;
      logic [SLOT_BITS-1:0] start_index;
      logic [ITEM_BITS-1:0] first_run;
      logic [ITEM_BITS-1:0] second_run;
      logic [ITEM_BITS-1:0] available_read;
      logic [ITEM_BITS-1:0] available_write;
   } rsp_type;

endpackage

### sv/rqpc_if.sv
// Handshake interfaces for the request, result and configuration channels.
interface rqpc_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic [rqpc_pkg::ITEM_BITS-1:0] count;

   modport source (output valid, command, count, input ready);
   modport sink   (input valid, command, count, output ready);
endinterface

interface rqpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [rqpc_pkg::SLOT_BITS-1:0] start_index;
   logic [rqpc_pkg::ITEM_BITS-1:0] first_run;
   logic [rqpc_pkg::ITEM_BITS-1:0] second_run;
   logic [rqpc_pkg::ITEM_BITS-1:0] available_read;
   logic [rqpc_pkg::ITEM_BITS-1:0] available_write;

   modport source (output valid, status, start_index, first_run, second_run,
                   available_read, available_write, input ready);
   modport sink   (input valid, status, start_index, first_run, second_run,
                   available_read, available_write, output ready);
endinterface

interface rqpc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rqpc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [rqpc_pkg::ITEM_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/rqpc_csr.sv
// Configuration registers: ring size with clamping, and the synchronised mode flag.
module rqpc_csr (
   input  logic              clock,
   input  logic              reset,
   rqpc_csr_if.sink          csr,
   output rqpc_pkg::cfg_type cfg
);
   import rqpc_pkg::*;

   logic [ITEM_BITS-1:0] ring_items_ff;
   logic [ITEM_BITS-1:0] ring_items_in;
   logic                 sync_mode_ff;
   logic                 sync_mode_in;
   logic                 clear_in;
   logic                 write_en;

   assign csr.ready = 1'b1;
   assign write_en  = csr.valid & csr.ready;

   // Decode a write; a ring size outside 1..RING_MAX is clamped into range.
   always_comb begin
      ring_items_in = ring_items_ff;
      sync_mode_in  = sync_mode_ff;
      clear_in      = 1'b0;
      if (write_en) begin
         unique case (csr.index)
            REG_RING_ITEMS: begin
               clear_in = 1'b1;
               if (csr.data == '0) begin
                  ring_items_in = ITEM_BITS'(1);
               end else if (csr.data > ITEM_BITS'(RING_MAX)) begin
                  ring_items_in = ITEM_BITS'(RING_MAX);
               end else begin
                  ring_items_in = csr.data;
               end
            end
            REG_SYNC_MODE: begin
               sync_mode_in = csr.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_items_ff <= ITEM_BITS'(RING_MAX);
         sync_mode_ff  <= 1'b1;
      end else begin
         ring_items_ff <= ring_items_in;
         sync_mode_ff  <= sync_mode_in;
      end
   end

   // The clear goes out with the write so the pointers reset at the same edge.
   assign cfg.ring_items = ring_items_ff;
   assign cfg.sync_mode  = sync_mode_ff;
   assign cfg.clear      = clear_in;

endmodule

### sv/rqpc_ptr.sv
// Pointer state and the single-pass grant, split and availability logic.
module rqpc_ptr (
   input  logic                           clock,
   input  logic                           reset,
   input  rqpc_pkg::cfg_type              cfg,
   input  logic                           step_en,
   input  logic [1:0]                     command,
   input  logic [rqpc_pkg::ITEM_BITS-1:0] count,
   output rqpc_pkg::rsp_type              rsp_next
);
   import rqpc_pkg::*;

   `include "ring_queue_pointer_control_assert.svh"

   // Only the difference of the free-running counters is observable, so the
   // fill level is held directly and wraps in the same way.
   logic [COUNT_BITS-1:0] fill_ff;
   logic [COUNT_BITS-1:0] fill_in;
   logic [SLOT_BITS-1:0]  rd_slot_ff;
   logic [SLOT_BITS-1:0]  rd_slot_in;
   logic [SLOT_BITS-1:0]  wr_slot_ff;
   logic [SLOT_BITS-1:0]  wr_slot_in;

   logic [ITEM_BITS-1:0]  ring;
   logic                  lapped;
   logic [ITEM_BITS-1:0]  fill_lo;
   logic [ITEM_BITS-1:0]  free_slots;
   logic [SLOT_BITS-1:0]  sel_slot;
   logic [ITEM_BITS-1:0]  room;
   logic [ITEM_BITS-1:0]  first;
   logic [ITEM_BITS-1:0]  slot_sum;
   logic [SLOT_BITS-1:0]  slot_adv;
   logic                  grant_wr;
   logic                  grant_rd;
   logic                  lap_rd;
   status_type            status;
   logic                  lapped_next;

   assign ring       = cfg.ring_items;
   assign lapped     = fill_ff > COUNT_BITS'(ring);
   assign fill_lo    = fill_ff[ITEM_BITS-1:0];
   assign free_slots = lapped ? '0 : ring - fill_lo;

   // Decide the outcome of the request.
   always_comb begin
      grant_wr = 1'b0;
      grant_rd = 1'b0;
      lap_rd   = 1'b0;
      status   = ST_GRANTED;
      case (command)
         CMD_WRITE: begin
            if (count == '0) begin
               status = ST_BAD_COUNT;
            end else if (count > ring || (cfg.sync_mode && free_slots < count)) begin
               status = ST_SHORT;
            end else begin
               grant_wr = 1'b1;
            end
         end
         CMD_READ: begin
            if (count == '0) begin
               status = ST_BAD_COUNT;
            end else if (lapped) begin
               status = ST_LAPPED;
               lap_rd = 1'b1;
            end else if (fill_lo < count) begin
               status = ST_SHORT;
            end else begin
               grant_rd = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Split of a granted transfer at the end of the ring, and the advanced slot.
   assign sel_slot = grant_rd ? rd_slot_ff : wr_slot_ff;
   assign room     = ring - ITEM_BITS'(sel_slot);
   assign first    = (count < room) ? count : room;
   assign slot_sum = ITEM_BITS'(sel_slot) + count;
   assign slot_adv = (slot_sum >= ring) ? SLOT_BITS'(slot_sum - ring)
                                        : SLOT_BITS'(slot_sum);

   // Next pointer state.
   always_comb begin
      fill_in    = fill_ff;
      rd_slot_in = rd_slot_ff;
      wr_slot_in = wr_slot_ff;
      if (grant_wr) begin
         fill_in    = fill_ff + COUNT_BITS'(count);
         wr_slot_in = slot_adv;
      end else if (grant_rd) begin
         fill_in    = fill_ff - COUNT_BITS'(count);
         rd_slot_in = slot_adv;
      end else if (lap_rd) begin
         fill_in    = '0;
         rd_slot_in = wr_slot_ff;
      end
   end

   assign lapped_next = fill_in > COUNT_BITS'(ring);

   // Result item, with the availability as it stands after the step.
   always_comb begin
      rsp_next.status          = status;
      rsp_next.start_index     = '0;
      rsp_next.first_run       = '0;
      rsp_next.second_run      = '0;
      if (grant_wr || grant_rd) begin
         rsp_next.start_index = sel_slot;
         rsp_next.first_run   = first;
         rsp_next.second_run  = count - first;
      end
      rsp_next.available_read  = lapped_next ? ring : fill_in[ITEM_BITS-1:0];
      rsp_next.available_write = lapped_next ? '0 : ring - fill_in[ITEM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         fill_ff    <= '0;
         rd_slot_ff <= '0;
         wr_slot_ff <= '0;
      end else if (step_en) begin
         fill_ff    <= fill_in;
         rd_slot_ff <= rd_slot_in;
         wr_slot_ff <= wr_slot_in;
      end
   end

   // Both slots stay inside the ring, the runs of a grant cover the request,
   // and the two availability counts always add up to the ring size.
   `RQPC_ASSERT_NOW(a_rd_slot_in_ring, 1'b1, rd_slot_ff < ring)
   `RQPC_ASSERT_NOW(a_wr_slot_in_ring, 1'b1, wr_slot_ff < ring)
   `RQPC_ASSERT_NOW(a_runs_cover, grant_wr || grant_rd,
                    rsp_next.first_run + rsp_next.second_run == count)
   `RQPC_ASSERT_NOW(a_avail_sum, 1'b1,
                    rsp_next.available_read + rsp_next.available_write == ring)

endmodule

### sv/ring_queue_pointer_control.sv
// Top level of the ring queue pointer control: input stage, result stage, submodules.
//
//   Channel   Direction  Payload
//   req_bus   in         command, count
//   rsp_bus   out        status, start_index, first_run, second_run,
//                        available_read, available_write
//   csr_bus   in         index, data (0 ring_items, 1 sync_mode)
//
// One item a cycle is accepted; an accepted item passes the input register and then
// the result register, from which its result is offered.
// The pointer logic works between the input register and the result register.
// A stalled result holds the result register; one more item waits in the input
// register, and the request side stalls only when both are full.
// Synchronous reset clears the pointers and sets a ring of 1024 in synchronised
// mode. Configuration writes are taken every cycle and need no clearing pass.
module ring_queue_pointer_control (
   input  logic        clock,
   input  logic        reset,
   rqpc_req_if.sink    req_bus,
   rqpc_rsp_if.source  rsp_bus,
   rqpc_csr_if.sink    csr_bus
);
   import rqpc_pkg::*;

   `include "ring_queue_pointer_control_assert.svh"

   cfg_type              cfg;
   rsp_type              rsp_next;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [1:0]           in_command_ff;
   logic [ITEM_BITS-1:0] in_count_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   logic                 advance;
   logic                 req_take;

   rqpc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   rqpc_ptr u_ptr (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step_en  (advance),
      .command  (in_command_ff),
      .count    (in_count_ff),
      .rsp_next (rsp_next)
   );

   // Handshake: an item moves on when the result register is empty or being taken.
   assign advance        = in_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready  = ~in_valid_ff | advance;
   assign req_take       = req_bus.valid & req_bus.ready;
   assign in_valid_in    = req_take | (in_valid_ff & ~advance);
   assign rsp_valid_in   = advance | (rsp_valid_ff & ~rsp_bus.ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_bus.command;
         in_count_ff   <= req_bus.count;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_data_ff.status;
   assign rsp_bus.start_index     = rsp_data_ff.start_index;
   assign rsp_bus.first_run       = rsp_data_ff.first_run;
   assign rsp_bus.second_run      = rsp_data_ff.second_run;
   assign rsp_bus.available_read  = rsp_data_ff.available_read;
   assign rsp_bus.available_write = rsp_data_ff.available_write;

   // An accepted item lands in the input stage, moves on into an empty result
   // stage, and a taken result with nothing behind it leaves the output empty.
   `RQPC_ASSERT_NEXT(a_req_lands, req_bus.valid && req_bus.ready, in_valid_ff)
   `RQPC_ASSERT_NEXT(a_item_moves, in_valid_ff && !rsp_valid_ff, rsp_valid_ff)
   `RQPC_ASSERT_NEXT(a_rsp_drains, rsp_bus.valid && rsp_bus.ready && !in_valid_ff,
                     !rsp_bus.valid)

endmodule

### dv/rqpc_result_check.sv
// Result checker for the ring queue pointer control: predicts every result and compares it.
module rqpc_result_check (
   input  logic clock,
   input  logic reset,
   rqpc_req_if  req_bus,
   rqpc_rsp_if  rsp_bus,
   rqpc_csr_if  csr_bus,
   output int   fail_total,
   output int   awaiting
);
   import rqpc_pkg::*;

   // Own copy of the configuration and of the pointers.
   logic [ITEM_BITS-1:0]  ring_size;
   logic                  sync_on;
   logic [COUNT_BITS-1:0] rd_total;
   logic [COUNT_BITS-1:0] wr_total;
   logic [SLOT_BITS-1:0]  rd_slot;
   logic [SLOT_BITS-1:0]  wr_slot;

   rsp_type expected_results[$];
   rsp_type oldest;
   int      mismatch_count = 0;

   // Prints one line per mismatch and counts it.
   task automatic report(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic void clear_pointers();
      rd_total = '0;
      wr_total = '0;
      rd_slot  = '0;
      wr_slot  = '0;
   endfunction

   // Slot reached after moving n items on from a slot, wrapped inside the ring.
   function automatic logic [SLOT_BITS-1:0] next_slot(logic [SLOT_BITS-1:0] slot,
                                                      logic [ITEM_BITS-1:0] n);
      int unsigned s;
      s = slot + n;
      if (s >= ring_size) s -= ring_size;
      if (s >= ring_size) s = 0;
      return SLOT_BITS'(s);
   endfunction

   // Splits a granted transfer into the run up to the wrap and the run after it.
   function automatic void fill_runs(input logic [SLOT_BITS-1:0] slot,
                                     input logic [ITEM_BITS-1:0] n, inout rsp_type r);
      logic [ITEM_BITS-1:0] room;
      logic [ITEM_BITS-1:0] first;
      room  = (slot < ring_size) ? ring_size - slot : '0;
      first = (n < room) ? n : room;
      r.start_index = slot;
      r.first_run   = first;
      r.second_run  = n - first;
   endfunction

   // Works out the result of one request and moves the pointers on.
   function automatic rsp_type predict_item(logic [1:0] cmd, logic [ITEM_BITS-1:0] n);
      rsp_type               r;
      logic [COUNT_BITS-1:0] fill;
      logic [COUNT_BITS-1:0] free_slots;
      logic                  lapped;
      r        = '0;
      r.status = ST_GRANTED;
      fill     = wr_total - rd_total;
      lapped   = fill > ring_size;
      case (cmd)
         CMD_WRITE: begin
            free_slots = lapped ? '0 : ring_size - fill;
            if (n == 0) begin
               r.status = ST_BAD_COUNT;
            end else if (n > ring_size || (sync_on && free_slots < n)) begin
               r.status = ST_SHORT;
            end else begin
               fill_runs(wr_slot, n, r);
               wr_total = wr_total + n;
               wr_slot  = next_slot(wr_slot, n);
            end
         end
         CMD_READ: begin
            if (n == 0) begin
               r.status = ST_BAD_COUNT;
            end else if (lapped) begin
               // The writer has lapped the reader: the reader jumps to the writer.
               rd_total = wr_total;
               rd_slot  = wr_slot;
               r.status = ST_LAPPED;
            end else if (fill < n) begin
               r.status = ST_SHORT;
            end else begin
               fill_runs(rd_slot, n, r);
               rd_total = rd_total + n;
               rd_slot  = next_slot(rd_slot, n);
            end
         end
         default: begin
         end
      endcase
      fill   = wr_total - rd_total;
      lapped = fill > ring_size;
      r.available_read  = lapped ? ring_size : fill[ITEM_BITS-1:0];
      r.available_write = lapped ? '0 : ring_size - fill[ITEM_BITS-1:0];
      return r;
   endfunction

   // A ring size write clamps the value and clears the pointers.
   function automatic void apply_register(logic [CSR_INDEX_BITS-1:0] idx,
                                          logic [ITEM_BITS-1:0] value);
      case (idx)
         REG_RING_ITEMS: begin
            if (value == 0) ring_size = ITEM_BITS'(1);
            else if (value > RING_MAX) ring_size = ITEM_BITS'(RING_MAX);
            else ring_size = value;
            clear_pointers();
         end
         REG_SYNC_MODE: sync_on = value[0];
         default: begin
         end
      endcase
   endfunction

   // Results are checked before the requests of the same edge are predicted.
   always @(posedge clock) begin
      if (reset) begin
         ring_size = ITEM_BITS'(RING_MAX);
         sync_on   = 1'b1;
         clear_pointers();
         expected_results.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report("result item with no request waiting", rsp_bus.status, 0);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_bus.status !== oldest.status)
                  report("status", rsp_bus.status, oldest.status);
               if (rsp_bus.start_index !== oldest.start_index)
                  report("start_index", rsp_bus.start_index, oldest.start_index);
               if (rsp_bus.first_run !== oldest.first_run)
                  report("first_run", rsp_bus.first_run, oldest.first_run);
               if (rsp_bus.second_run !== oldest.second_run)
                  report("second_run", rsp_bus.second_run, oldest.second_run);
               if (rsp_bus.available_read !== oldest.available_read)
                  report("available_read", rsp_bus.available_read, oldest.available_read);
               if (rsp_bus.available_write !== oldest.available_write)
                  report("available_write", rsp_bus.available_write,
                         oldest.available_write);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            apply_register(csr_bus.index, csr_bus.data);
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(predict_item(req_bus.command, req_bus.count));
         end
      end
      fail_total <= mismatch_count;
      awaiting   <= expected_results.size();
   end

endmodule

### dv/tb.sv
// Top of the ring queue pointer control testbench: clock, reset, stimulus and verdict.
module tb;
   import rqpc_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 8;
   localparam int QUIET_LIMIT     = 2000;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PRESSURE_PHASE  = 4;

   // The command code that the block treats as a status query.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNKNOWN = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rqpc_req_if req_bus ();
   rqpc_rsp_if rsp_bus ();
   rqpc_csr_if csr_bus ();

   int fail_total;
   int awaiting;

   // Idling controls, written by the stimulus process only.
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_arm      = 1'b0;

   // Owned by the receiver process.
   int unsigned hold_left  = 0;
   logic        hold_taken = 1'b0;

   int unsigned quiet_cycles = 0;
   int unsigned active_ring  = RING_MAX;

   // Ring sizes of the random phases, out-of-range values among them.
   int unsigned ring_plan [PHASES] = '{1024, 1, 2, 5, 16, 64, 2047, 0, 1000, 37, 300, 1023};

   ring_queue_pointer_control uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rqpc_result_check result_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_total (fail_total),
      .awaiting   (awaiting)
   );

   always #CLOCK_HALF clock = ~clock;

   // Receiver: random stalls, plus one long hold-off counted here when armed.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_arm && !hold_taken) begin
            hold_left  = LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Offers one request item, with random idle cycles first, and waits until it is taken.
   task automatic offer_request(logic [1:0] cmd, logic [ITEM_BITS-1:0] n);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.command = cmd;
      req_bus.count   = n;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx, logic [ITEM_BITS-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Keeps track of the ring size in force, so that counts can be chosen around it.
   task automatic set_ring(int unsigned value);
      write_register(REG_RING_ITEMS, ITEM_BITS'(value));
      if (value == 0) active_ring = 1;
      else if (value > RING_MAX) active_ring = RING_MAX;
      else active_ring = value;
   endtask

   // Stops offering and waits until every result has come back.
   task automatic settle();
      req_bus.valid = 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   function automatic logic [1:0] pick_command();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return CMD_QUERY;
      if (roll < 10) return CMD_UNUSED;
      if (roll < 55) return CMD_WRITE;
      return CMD_READ;
   endfunction

   // Mostly counts that fit the ring, some zero and some beyond it.
   function automatic logic [ITEM_BITS-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 15 && active_ring < 2047) return ITEM_BITS'($urandom_range(2047, active_ring + 1));
      if (roll < 40) return ITEM_BITS'($urandom_range(active_ring, 1));
      return ITEM_BITS'($urandom_range(active_ring / 3 + 1, 1));
   endfunction

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_QUERY;
      req_bus.count   = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = REG_RING_ITEMS;
      csr_bus.data    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items on the full ring in synchronised mode.
      offer_request(CMD_QUERY, '0);
      offer_request(CMD_UNUSED, ITEM_BITS'(5));
      offer_request(CMD_WRITE, '0);
      offer_request(CMD_READ, '0);
      offer_request(CMD_READ, ITEM_BITS'(1));
      offer_request(CMD_WRITE, '1);
      offer_request(CMD_WRITE, ITEM_BITS'(1024));
      offer_request(CMD_WRITE, ITEM_BITS'(1));
      offer_request(CMD_READ, ITEM_BITS'(1024));
      offer_request(CMD_WRITE, ITEM_BITS'(1000));
      offer_request(CMD_WRITE, ITEM_BITS'(100));
      offer_request(CMD_READ, ITEM_BITS'(1000));
      offer_request(CMD_READ, ITEM_BITS'(100));

      // A ring size of zero is taken as one; the writer may overrun.
      settle();
      write_register(REG_UNKNOWN, '1);
      set_ring(0);
      write_register(REG_SYNC_MODE, '0);
      offer_request(CMD_WRITE, ITEM_BITS'(1));
      offer_request(CMD_WRITE, ITEM_BITS'(1));
      offer_request(CMD_QUERY, '0);
      offer_request(CMD_WRITE, ITEM_BITS'(1));
      offer_request(CMD_READ, '1);
      offer_request(CMD_READ, ITEM_BITS'(1));

      // An oversized ring value is clamped; a full lap by the writer.
      settle();
      set_ring(2047);
      offer_request(CMD_WRITE, ITEM_BITS'(1024));
      offer_request(CMD_WRITE, ITEM_BITS'(1024));
      offer_request(CMD_READ, ITEM_BITS'(1));

      // Random phases, each with its own ring size, mode and idling.
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         settle();
         set_ring(ring_plan[phase]);
         write_register(REG_SYNC_MODE, ITEM_BITS'($urandom_range(1023) * 2 + phase % 2));
         write_register(CSR_INDEX_BITS'($urandom_range(255, 2)),
                        ITEM_BITS'($urandom_range(2047)));
         case (phase % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 80;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 80;
            end
            default: begin
               req_idle_pct  = 29;
               rsp_stall_pct = 29;
            end
         endcase
         // The receiver holds off while the sender keeps offering at full rate.
         if (phase == PRESSURE_PHASE) hold_arm = 1'b1;
         repeat (ITEMS_PER_PHASE) offer_request(pick_command(), pick_count());
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_total == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
